// ===== hw/rtl/lbd_pkg.sv =====
// Package for the LED bank dirty update engine.
// Holds sizing constants, command and state types, and the gamma table.
// No dependencies; used by every RTL file of the block.
package lbd_pkg;

    localparam int BANK_LEDS  = 8;
    localparam int BANK_COUNT = 4;
    localparam int LED_COUNT  = BANK_LEDS * BANK_COUNT;

    localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int CNT_W  = (BANK_LEDS > 1) ? $clog2(BANK_LEDS) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BANK_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_ALL   = 2'd2;

    localparam logic [7:0] RST_BANK_BASE = 8'd128;
    localparam logic [7:0] RST_SET_ONE   = 8'd4;
    localparam logic [7:0] RST_SET_ALL   = 8'd3;

    typedef enum logic [1:0] {
        FUNC_STORE = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_ONE   = 2'd2,
        FUNC_ALL   = 2'd3
    } func_t;

    typedef struct packed {
        func_t             kind;
        logic [4:0]        led;
        logic              in_range;
        logic [BANK_W-1:0] bank;
        logic [23:0]       colour;   // red [23:16], green [15:8], blue [7:0]
        logic [7:0]        gam_r;
        logic [7:0]        gam_g;
        logic [7:0]        gam_b;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_BANK_CMD,
        ST_BANK_B,
        ST_BANK_G,
        ST_BANK_R,
        ST_ONE_CMD,
        ST_ONE_IDX,
        ST_ONE_B,
        ST_ONE_G,
        ST_ONE_R,
        ST_ALL_CMD,
        ST_ALL_B,
        ST_ALL_G,
        ST_ALL_R
    } back_state_t;

    function automatic logic [7:0] gamma_lut(input logic [7:0] level);
        logic [4:0] idx;
        logic [7:0] val;
        idx = (level > 8'd31) ? 5'd31 : level[4:0];
        case (idx)
            5'd0:    val = 8'd0;
            5'd1:    val = 8'd1;
            5'd2:    val = 8'd2;
            5'd3:    val = 8'd3;
            5'd4:    val = 8'd4;
            5'd5:    val = 8'd5;
            5'd6:    val = 8'd7;
            5'd7:    val = 8'd8;
            5'd8:    val = 8'd10;
            5'd9:    val = 8'd11;
            5'd10:   val = 8'd13;
            5'd11:   val = 8'd15;
            5'd12:   val = 8'd18;
            5'd13:   val = 8'd22;
            5'd14:   val = 8'd25;
            5'd15:   val = 8'd32;
            5'd16:   val = 8'd40;
            5'd17:   val = 8'd49;
            5'd18:   val = 8'd59;
            5'd19:   val = 8'd68;
            5'd20:   val = 8'd78;
            5'd21:   val = 8'd89;
            5'd22:   val = 8'd101;
            5'd23:   val = 8'd114;
            5'd24:   val = 8'd127;
            5'd25:   val = 8'd142;
            5'd26:   val = 8'd158;
            5'd27:   val = 8'd175;
            5'd28:   val = 8'd193;
            5'd29:   val = 8'd213;
            5'd30:   val = 8'd233;
            5'd31:   val = 8'd255;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/lbd_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
// Computes range check, bank number and gamma bytes. Depends on lbd_pkg.
module lbd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // led_index, red, green, blue, zero fill
    input  logic [1:0]    s_tuser,   // func
    output logic          push_valid,
    input  logic          push_ready,
    output lbd_pkg::cmd_t push_data
);
    import lbd_pkg::*;

    logic hold_valid_reg;
    cmd_t hold_cmd_reg;
    cmd_t decoded;
    logic accept;

    function automatic logic [BANK_W-1:0] bank_of(input logic [4:0] led);
        logic [BANK_W-1:0] bank;
        bank = '0;
        for (int b = 1; b < BANK_COUNT; b++)
        begin
            if (32'(led) >= b * BANK_LEDS)
            begin
                bank = BANK_W'(b);
            end
        end
        return bank;
    endfunction

    always_comb
    begin
        decoded.kind     = func_t'(s_tuser);
        decoded.led      = s_tdata[4:0];
        decoded.in_range = (32'(s_tdata[4:0]) < LED_COUNT);
        decoded.bank     = bank_of(s_tdata[4:0]);
        decoded.colour   = {s_tdata[12:5], s_tdata[20:13], s_tdata[28:21]};
        decoded.gam_r    = gamma_lut(s_tdata[12:5]);
        decoded.gam_g    = gamma_lut(s_tdata[20:13]);
        decoded.gam_b    = gamma_lut(s_tdata[28:21]);
    end

    assign s_tready   = !hold_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = hold_valid_reg;
    assign push_data  = hold_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= decoded;
        end
    end

endmodule

// ===== hw/rtl/lbd_queue.sv =====
// Command queue between front end and back end.
// Small register FIFO of lbd_pkg::cmd_t entries. Depends on lbd_pkg.
module lbd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  lbd_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop,
    output lbd_pkg::cmd_t pop_data
);
    import lbd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/lbd_back.sv =====
// Back end: executes commands, owns the colour memory, dirty bits, bank pointer
// and command registers, and emits packet bytes through an output register.
// Depends on lbd_pkg.
module lbd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  lbd_pkg::cmd_t                 q_data,
    input  logic                          cfg_we,
    input  logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbd_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // packet_byte
    output logic                          m_tlast    // last_byte
);
    import lbd_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cur_reg;
    logic [BANK_W-1:0] bank_reg;
    logic [BANK_W-1:0] ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LED_W-1:0]  addr_reg;
    logic [BANK_COUNT-1:0] dirty_reg;
    logic [LED_COUNT-1:0]  valid_reg;
    logic [23:0]       fill_reg;
    logic [23:0]       rd_data_reg;
    logic              rd_hit_reg;
    logic [7:0]        base_cmd_reg;
    logic [7:0]        one_cmd_reg;
    logic [7:0]        all_cmd_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    logic [23:0]       colour_mem [LED_COUNT];

    logic              load_ok;
    logic [23:0]       eff;
    logic              bank_last;
    logic [LED_W-1:0]  bank_start;

    logic              emit;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic              mem_we;
    logic [LED_W-1:0]  mem_waddr;
    logic [23:0]       mem_wdata;
    logic              mem_re;
    logic [LED_W-1:0]  mem_raddr;
    logic              set_dirty;
    logic              clr_dirty;
    logic              all_clear;
    logic              ptr_adv;

    assign load_ok    = !out_valid_reg || m_tready;
    assign eff        = rd_hit_reg ? rd_data_reg : fill_reg;
    assign bank_last  = (cnt_reg == CNT_W'(BANK_LEDS - 1));
    assign bank_start = LED_W'(32'(bank_reg) * BANK_LEDS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.kind)
                        FUNC_STORE: state_next = q_data.in_range ? ST_CMP : ST_IDLE;
                        FUNC_TICK:  state_next = dirty_reg[ptr_reg] ? ST_BANK_CMD : ST_IDLE;
                        FUNC_ONE:   state_next = ST_ONE_CMD;
                        FUNC_ALL:   state_next = ST_ALL_CMD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CMP:      state_next = ST_IDLE;
            ST_BANK_CMD: state_next = load_ok ? ST_BANK_B : ST_BANK_CMD;
            ST_BANK_B:   state_next = load_ok ? ST_BANK_G : ST_BANK_B;
            ST_BANK_G:   state_next = load_ok ? ST_BANK_R : ST_BANK_G;
            ST_BANK_R:
            begin
                if (load_ok)
                begin
                    state_next = bank_last ? ST_IDLE : ST_BANK_B;
                end
            end
            ST_ONE_CMD:  state_next = load_ok ? ST_ONE_IDX : ST_ONE_CMD;
            ST_ONE_IDX:  state_next = load_ok ? ST_ONE_B : ST_ONE_IDX;
            ST_ONE_B:    state_next = load_ok ? ST_ONE_G : ST_ONE_B;
            ST_ONE_G:    state_next = load_ok ? ST_ONE_R : ST_ONE_G;
            ST_ONE_R:    state_next = load_ok ? ST_IDLE : ST_ONE_R;
            ST_ALL_CMD:  state_next = load_ok ? ST_ALL_B : ST_ALL_CMD;
            ST_ALL_B:    state_next = load_ok ? ST_ALL_G : ST_ALL_B;
            ST_ALL_G:    state_next = load_ok ? ST_ALL_R : ST_ALL_G;
            ST_ALL_R:    state_next = load_ok ? ST_IDLE : ST_ALL_R;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = LED_W'(cur_reg.led);
        mem_wdata = cur_reg.colour;
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        set_dirty = 1'b0;
        clr_dirty = 1'b0;
        all_clear = 1'b0;
        ptr_adv   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    case (q_data.kind)
                        FUNC_STORE:
                        begin
                            mem_re    = q_data.in_range;
                            mem_raddr = LED_W'(q_data.led);
                        end
                        FUNC_TICK:
                        begin
                            ptr_adv = 1'b1;
                        end
                        FUNC_ONE:
                        begin
                            mem_we    = q_data.in_range;
                            mem_waddr = LED_W'(q_data.led);
                            mem_wdata = q_data.colour;
                        end
                        FUNC_ALL:
                        begin
                            all_clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (eff != cur_reg.colour)
                begin
                    mem_we    = 1'b1;
                    set_dirty = 1'b1;
                end
            end
            ST_BANK_CMD:
            begin
                emit      = load_ok;
                emit_byte = base_cmd_reg + 8'(bank_reg);
                mem_re    = load_ok;
                mem_raddr = bank_start;
            end
            ST_BANK_B:
            begin
                emit      = load_ok;
                emit_byte = gamma_lut(eff[7:0]);
            end
            ST_BANK_G:
            begin
                emit      = load_ok;
                emit_byte = gamma_lut(eff[15:8]);
            end
            ST_BANK_R:
            begin
                emit      = load_ok;
                emit_byte = gamma_lut(eff[23:16]);
                emit_last = bank_last;
                mem_re    = load_ok && !bank_last;
                mem_raddr = addr_reg + 1'b1;
                clr_dirty = load_ok && bank_last;
            end
            ST_ONE_CMD:
            begin
                emit      = load_ok;
                emit_byte = one_cmd_reg;
            end
            ST_ONE_IDX:
            begin
                emit      = load_ok;
                emit_byte = 8'(cur_reg.led);
            end
            ST_ONE_B, ST_ALL_B:
            begin
                emit      = load_ok;
                emit_byte = cur_reg.gam_b;
            end
            ST_ONE_G, ST_ALL_G:
            begin
                emit      = load_ok;
                emit_byte = cur_reg.gam_g;
            end
            ST_ONE_R, ST_ALL_R:
            begin
                emit      = load_ok;
                emit_byte = cur_reg.gam_r;
                emit_last = 1'b1;
            end
            ST_ALL_CMD:
            begin
                emit      = load_ok;
                emit_byte = all_cmd_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            dirty_reg     <= '0;
            valid_reg     <= '0;
            fill_reg      <= '0;
            base_cmd_reg  <= RST_BANK_BASE;
            one_cmd_reg   <= RST_SET_ONE;
            all_cmd_reg   <= RST_SET_ALL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ptr_adv)
            begin
                ptr_reg <= (ptr_reg == BANK_W'(BANK_COUNT - 1)) ? '0 : ptr_reg + 1'b1;
            end
            if (all_clear)
            begin
                dirty_reg <= '0;
                valid_reg <= '0;
                fill_reg  <= q_data.colour;
            end
            else
            begin
                if (set_dirty)
                begin
                    dirty_reg[cur_reg.bank] <= 1'b1;
                end
                if (clr_dirty)
                begin
                    dirty_reg[bank_reg] <= 1'b0;
                end
                if (mem_we)
                begin
                    valid_reg[mem_waddr] <= 1'b1;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BANK_BASE: base_cmd_reg <= cfg_wdata;
                    CFG_SET_ONE:   one_cmd_reg  <= cfg_wdata;
                    CFG_SET_ALL:   all_cmd_reg  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (state_reg == ST_IDLE && q_valid && q_data.kind == FUNC_TICK)
        begin
            bank_reg <= ptr_reg;
        end
        if (state_reg == ST_BANK_CMD && load_ok)
        begin
            cnt_reg  <= '0;
            addr_reg <= bank_start;
        end
        else if (state_reg == ST_BANK_R && load_ok)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            addr_reg <= addr_reg + 1'b1;
        end
        if (emit)
        begin
            out_data_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            colour_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= colour_mem[mem_raddr];
            rd_hit_reg  <= valid_reg[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/led_bank_dirty_update_engine_unit.sv =====
// Path: a command passes the front-end hold register and the queue before the back end
// takes it; the first packet byte is then registered in the output register.
// Throughput: one packet byte per cycle while m_tready does not stall the output; a dirty
// bank tick emits 25 bytes, one LED 5, all LEDs 4, and store colour and clean tick none.
// Reset clears dirty bits, bank pointer and LED valid bits and loads the command registers
// with their defaults; unwritten colour entries read as the last fill colour (zero).
module led_bank_dirty_update_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // led_index, red, green, blue
    input  logic [1:0]                    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // packet_byte
    output logic                          m_tlast,   // last_byte
    input  logic                          cfg_we,
    input  logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbd_pkg::CFG_W-1:0]     cfg_wdata
);
    import lbd_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic q_valid;
    logic q_pop;
    cmd_t q_data;

    lbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    lbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/led_packet_checker.sv =====
// Checker for the LED bank dirty update engine: predicts every packet byte from
// the accepted commands and register writes, and compares the output stream.
// Depends on lbd_pkg for sizes and the command enum.
module led_packet_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // led_index, red, green, blue
    input  logic [1:0]                    s_tuser,   // func
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,   // packet_byte
    input  logic                          m_tlast,   // last_byte
    input  logic                          cfg_we,
    input  logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbd_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packet_byte_t;

    localparam logic [7:0] GAMMA_CURVE [32] = '{
        8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd7,   8'd8,
        8'd10,  8'd11,  8'd13,  8'd15,  8'd18,  8'd22,  8'd25,  8'd32,
        8'd40,  8'd49,  8'd59,  8'd68,  8'd78,  8'd89,  8'd101, 8'd114,
        8'd127, 8'd142, 8'd158, 8'd175, 8'd193, 8'd213, 8'd233, 8'd255
    };

    packet_byte_t      expected_bytes [$];
    logic [7:0]        led_red   [LED_COUNT];
    logic [7:0]        led_green [LED_COUNT];
    logic [7:0]        led_blue  [LED_COUNT];
    logic [BANK_COUNT-1:0] dirty_banks;
    logic [BANK_W-1:0] next_bank;
    logic [7:0]        bank_base;
    logic [7:0]        one_cmd;
    logic [7:0]        all_cmd;

    assign pending = expected_bytes.size();

    initial errors = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [7:0] corrected(input logic [7:0] level);
        return GAMMA_CURVE[(level > 8'd31) ? 31 : level[4:0]];
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic last);
        expected_bytes.push_back('{data: data, last: last});
    endtask

    task automatic predict_packet(input func_t kind, input logic [4:0] led,
                                  input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
        int n;
        logic [BANK_W-1:0] bank;
        case (kind)
            FUNC_STORE:
            begin
                if (led < LED_COUNT &&
                    (led_red[led] != r || led_green[led] != g || led_blue[led] != b))
                begin
                    led_red[led]   = r;
                    led_green[led] = g;
                    led_blue[led]  = b;
                    dirty_banks[led / BANK_LEDS] = 1'b1;
                end
            end
            FUNC_TICK:
            begin
                bank = next_bank;
                next_bank = (bank == BANK_COUNT - 1) ? '0 : bank + 1'b1;
                if (dirty_banks[bank])
                begin
                    queue_byte(bank_base + 8'(bank), 1'b0);
                    for (int i = 0; i < BANK_LEDS; i++)
                    begin
                        n = bank * BANK_LEDS + i;
                        queue_byte(corrected(led_blue[n]), 1'b0);
                        queue_byte(corrected(led_green[n]), 1'b0);
                        queue_byte(corrected(led_red[n]), i == BANK_LEDS - 1);
                    end
                    dirty_banks[bank] = 1'b0;
                end
            end
            FUNC_ONE:
            begin
                queue_byte(one_cmd, 1'b0);
                queue_byte({3'b000, led}, 1'b0);
                queue_byte(corrected(b), 1'b0);
                queue_byte(corrected(g), 1'b0);
                queue_byte(corrected(r), 1'b1);
                if (led < LED_COUNT)
                begin
                    led_red[led]   = r;
                    led_green[led] = g;
                    led_blue[led]  = b;
                end
            end
            default:
            begin
                queue_byte(all_cmd, 1'b0);
                queue_byte(corrected(b), 1'b0);
                queue_byte(corrected(g), 1'b0);
                queue_byte(corrected(r), 1'b1);
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    led_red[i]   = r;
                    led_green[i] = g;
                    led_blue[i]  = b;
                end
                dirty_banks = '0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packet_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            for (int i = 0; i < LED_COUNT; i++)
            begin
                led_red[i]   = '0;
                led_green[i] = '0;
                led_blue[i]  = '0;
            end
            dirty_banks = '0;
            next_bank   = '0;
            bank_base   = 8'd128;
            one_cmd     = 8'd4;
            all_cmd     = 8'd3;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected byte %0d last %0b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("packet byte %0d, want %0d",
                                                  m_tdata, want.data));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last flag %0b, want %0b on byte %0d",
                                                  m_tlast, want.last, want.data));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BANK_BASE: bank_base = cfg_wdata;
                    CFG_SET_ONE:   one_cmd   = cfg_wdata;
                    CFG_SET_ALL:   all_cmd   = cfg_wdata;
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_packet(func_t'(s_tuser), s_tdata[4:0], s_tdata[12:5],
                               s_tdata[20:13], s_tdata[28:21]);
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the LED bank dirty update engine bench: clock, reset, command and
// register stimulus, output backpressure and the verdict.
// Depends on lbd_pkg, the engine RTL and led_packet_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // led_index, red, green, blue
    logic [1:0]           s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // packet_byte
    logic                 m_tlast;   // last_byte
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   errors;
    int                   pending;
    logic                 calm = 1'b0;
    logic [4:0]           last_led = '0;
    logic [7:0]           last_r = '0;
    logic [7:0]           last_g = '0;
    logic [7:0]           last_b = '0;

    led_bank_dirty_update_engine_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    led_packet_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= 9);
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_cmd(input func_t kind, input logic [4:0] led,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
        while (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, b, g, r, led};
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off until every predicted byte is out, then let the engine go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] base, input logic [7:0] one,
                                input logic [7:0] all);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BANK_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_SET_ONE;
        cfg_wdata <= one;
        @(posedge clk);
        cfg_index <= CFG_SET_ALL;
        cfg_wdata <= all;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= 8'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(40));
            1:       return $urandom_range(1) ? 8'd31 : 8'd32;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_cmd();
        int         sel;
        func_t      kind;
        logic [4:0] led;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        sel = $urandom_range(99);
        led = 5'($urandom_range(31));
        r   = pick_level();
        g   = pick_level();
        b   = pick_level();
        if (sel < 45)
        begin
            kind = FUNC_STORE;
            if ($urandom_range(4) == 0)
            begin
                led = last_led;
                r   = last_r;
                g   = last_g;
                b   = last_b;
            end
            last_led = led;
            last_r   = r;
            last_g   = g;
            last_b   = b;
        end
        else if (sel < 80)
            kind = FUNC_TICK;
        else if (sel < 94)
            kind = FUNC_ONE;
        else
            kind = FUNC_ALL;
        send_cmd(kind, led, r, g, b);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_STORE;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BANK_BASE;
        cfg_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_STORE, 5'd0,  8'd255, 8'd0,   8'd31);
        send_cmd(FUNC_STORE, 5'd0,  8'd255, 8'd0,   8'd31);
        send_cmd(FUNC_STORE, 5'd31, 8'd32,  8'd31,  8'd255);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_ONE,   5'd5,  8'd1,   8'd2,   8'd3);
        send_cmd(FUNC_ONE,   5'd31, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_ONE,   5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_STORE, 5'd9,  8'd100, 8'd30,  8'd31);
        send_cmd(FUNC_ALL,   5'd0,  8'd200, 8'd0,   8'd17);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_STORE, 5'd20, 8'd200, 8'd0,   8'd17);
        send_cmd(FUNC_STORE, 5'd15, 8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_STORE, 5'd23, 8'd12,  8'd13,  8'd14);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_TICK,  5'd0,  8'd0,   8'd0,   8'd0);
        send_cmd(FUNC_ALL,   5'd31, 8'd255, 8'd255, 8'd255);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       program_regs(8'h00, 8'hFF, 8'h00);
                1:       program_regs(8'hFF, 8'h00, 8'hFF);
                default: program_regs(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 66; n++)
            begin
                if (phase == 1 && n == 30)
                    drain();
                random_cmd();
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lbd_pkg.sv
hw/rtl/lbd_front.sv
hw/rtl/lbd_queue.sv
hw/rtl/lbd_back.sv
hw/rtl/led_bank_dirty_update_engine_unit.sv
bench/led_packet_checker.sv
bench/tb.sv
